// File: sv/pca_pkg.sv
// Package: shared constants and payload types for the path capacity admission block.
package pca_pkg;

  localparam int unsigned NumStops = 2048;
  localparam int unsigned AddrW    = $clog2(NumStops);
  localparam int unsigned CntW     = AddrW + 1;
  localparam int unsigned LoadW    = 14;
  localparam int unsigned TotalW   = 32;

  localparam logic [LoadW-1:0] CapReset = {LoadW{1'b1}};

  typedef struct packed {
    logic [10:0]      start_stop;
    logic [11:0]      end_stop;
    logic [LoadW-1:0] amount;
    logic             last_request;
  } req_t;

  typedef struct packed {
    logic [LoadW-1:0]  granted;
    logic [TotalW-1:0] total_granted;
    logic              batch_done;
  } rsp_t;

endpackage

// File: sv/path_capacity_admission_core.sv
// Top level: greedy capacity admission over a linear route, load store in one RAM.
//
// Usage:
//   Requests enter on in_valid_i/in_ready_o with payload in_data_i, one item per
//   handshake. Each request reads every segment load of its span to find the
//   peak, grants min(amount, capacity - peak) (zero when the peak reaches
//   capacity), then read-modify-writes the grant into each segment of the span.
//   Results leave on out_valid_o/out_ready_i from an output register; the next
//   request is taken while a finished result still waits to be drained.
//   Per request, the scan reads each segment of the span, then the update
//   (skipped for a zero grant) reads and writes each segment again, where
//   span = min(end_stop, 2048) - start_stop. The next request is taken only
//   after the current one has reached StDone and handed off its result. The
//   single read and single write port of the load RAM set the pace: one
//   segment read per cycle in the scan, one read plus one write per cycle in the update.
//   Reset: rst_ni clears control state, sets capacity to 16383 and the running
//   total to zero, then a clearing pass writes zero to all 2048 load entries,
//   during which in_ready_o stays low. Capacity writes via
//   cfg_we_i/cfg_wdata_i are taken at any time, also during the clearing pass.
//   Stall: if out_ready_i is low when a second result finishes, the block holds
//   it internally until the output register drains; loads are already updated.
module path_capacity_admission_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  pca_pkg::req_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output pca_pkg::rsp_t              out_data_o,
  input  logic                       cfg_we_i,
  input  logic [pca_pkg::LoadW-1:0]  cfg_wdata_i
);

  // Sequencer states
  localparam logic [2:0] StClear  = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StScan   = 3'd2;
  localparam logic [2:0] StDecide = 3'd3;
  localparam logic [2:0] StUpdate = 3'd4;
  localparam logic [2:0] StDone   = 3'd5;

  logic [2:0] state_q, state_d;

  // Request fields held for the whole item
  logic [pca_pkg::CntW-1:0]   first_q, first_d;
  logic [pca_pkg::CntW-1:0]   stop_q, stop_d;
  logic [pca_pkg::LoadW-1:0]  amount_q, amount_d;
  logic                       last_q, last_d;

  // Span walk and datapath
  logic [pca_pkg::CntW-1:0]   idx_q, idx_d;
  logic                       rd_vld_q, rd_vld_d;
  logic [pca_pkg::AddrW-1:0]  rd_addr_q, rd_addr_d;
  logic [pca_pkg::LoadW-1:0]  peak_q, peak_d;
  logic [pca_pkg::LoadW-1:0]  grant_q, grant_d;
  logic [pca_pkg::LoadW-1:0]  cap_q;
  logic [pca_pkg::TotalW-1:0] total_q, total_d;

  // Output register
  logic                       out_vld_q, out_vld_d;
  pca_pkg::rsp_t              out_q, out_d;

  // Load RAM
  logic [pca_pkg::LoadW-1:0]  seg_mem [pca_pkg::NumStops];
  logic [pca_pkg::LoadW-1:0]  rdata_q;
  logic                       mem_re;
  logic [pca_pkg::AddrW-1:0]  mem_raddr;
  logic                       mem_we;
  logic [pca_pkg::AddrW-1:0]  mem_waddr;
  logic [pca_pkg::LoadW-1:0]  mem_wdata;

  logic [pca_pkg::CntW-1:0]   end_clamped;
  logic [pca_pkg::LoadW-1:0]  headroom;
  logic [pca_pkg::TotalW:0]   total_sum;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // end_stop beyond the route means the route's end
  assign end_clamped = (in_data_i.end_stop > pca_pkg::CntW'(pca_pkg::NumStops)) ?
                       pca_pkg::CntW'(pca_pkg::NumStops) : in_data_i.end_stop;

  assign headroom  = (cap_q > peak_q) ? (cap_q - peak_q) : '0;
  assign total_sum = {1'b0, total_q} + (pca_pkg::TotalW + 1)'(grant_q);

  always_comb begin
    state_d   = state_q;
    first_d   = first_q;
    stop_d    = stop_q;
    amount_d  = amount_q;
    last_d    = last_q;
    idx_d     = idx_q;
    rd_vld_d  = 1'b0;
    rd_addr_d = rd_addr_q;
    peak_d    = peak_q;
    grant_d   = grant_q;
    total_d   = total_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    mem_re    = 1'b0;
    mem_raddr = idx_q[pca_pkg::AddrW-1:0];
    mem_we    = 1'b0;
    mem_waddr = rd_addr_q;
    mem_wdata = rdata_q + grant_q;

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[pca_pkg::AddrW-1:0];
        mem_wdata = '0;
        idx_d     = idx_q + 1'b1;
        if (idx_q[pca_pkg::AddrW-1:0] == pca_pkg::AddrW'(pca_pkg::NumStops - 1)) begin
          idx_d   = '0;
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          first_d  = {1'b0, in_data_i.start_stop};
          stop_d   = end_clamped;
          amount_d = in_data_i.amount;
          last_d   = in_data_i.last_request;
          idx_d    = {1'b0, in_data_i.start_stop};
          peak_d   = '0;
          state_d  = StScan;
        end
      end
      StScan: begin
        // fold the word read last cycle, issue the next read
        if (rd_vld_q && (rdata_q > peak_q)) begin
          peak_d = rdata_q;
        end
        if (idx_q < stop_q) begin
          mem_re    = 1'b1;
          rd_addr_d = idx_q[pca_pkg::AddrW-1:0];
          rd_vld_d  = 1'b1;
          idx_d     = idx_q + 1'b1;
        end else if (!rd_vld_q) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        grant_d = (amount_q < headroom) ? amount_q : headroom;
        idx_d   = first_q;
        state_d = StUpdate;
        if (grant_d == '0) begin
          state_d = StDone;
        end
      end
      StUpdate: begin
        // write back entry j while reading j+1: never the same entry
        if (rd_vld_q) begin
          mem_we = 1'b1;
        end
        if (idx_q < stop_q) begin
          mem_re    = 1'b1;
          rd_addr_d = idx_q[pca_pkg::AddrW-1:0];
          rd_vld_d  = 1'b1;
          idx_d     = idx_q + 1'b1;
        end else if (!rd_vld_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_vld_q || out_ready_i) begin
          total_d   = total_sum[pca_pkg::TotalW] ? '1 : total_sum[pca_pkg::TotalW-1:0];
          out_d.granted       = grant_q;
          out_d.total_granted = total_d;
          out_d.batch_done    = last_q;
          out_vld_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      total_q   <= '0;
      cap_q     <= pca_pkg::CapReset;
      grant_q   <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      total_q   <= total_d;
      grant_q   <= grant_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    first_q   <= first_d;
    stop_q    <= stop_d;
    amount_q  <= amount_d;
    last_q    <= last_d;
    rd_addr_q <= rd_addr_d;
    peak_q    <= peak_d;
    out_q     <= out_d;
  end

  // Load RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= seg_mem[mem_raddr];
    end
  end

  // Assertions
  a_update_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == StUpdate) |->
      ({1'b0, mem_waddr} >= first_q && {1'b0, mem_waddr} < stop_q))
    else $error("load write outside request span");

  a_grant_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StUpdate) |-> (grant_q <= amount_q && grant_q != '0))
    else $error("grant exceeds request or update with zero grant");

  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StClear) |=> (total_q >= $past(total_q)))
    else $error("running total decreased");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write of the same load entry in one cycle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> (out_vld_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule
